// ===== rtl/core/apsm_pkg.sv =====
// Shared constants, types and field layout for the affine phase-space map.
package apsm_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = COEF_W - 10;
    localparam int NUM_ROWS   = 6;
    localparam int NUM_COLS   = NUM_ROWS + 1;
    localparam int TABLE_SIZE = NUM_ROWS * NUM_COLS;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    // Accumulation widths: products, pair sums, quad sums, full sum.
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int SUM2_W = PROD_W + 1;
    localparam int SUM3_W = PROD_W + 2;
    localparam int SUM4_W = PROD_W + 3;
    localparam int SHR_W  = SUM4_W - COEF_FRAC;
    localparam int RES_W  = SHR_W + 1;

    // Number of registered stages from acceptance to the output register inclusive.
    localparam int PIPE_DEPTH = 6;

    localparam logic signed [SUM3_W-1:0] ROUND_HALF = SUM3_W'(1) << (COEF_FRAC - 1);

    // Stream layout.
    localparam int IN_BITS    = IDX_W + COEF_W + NUM_ROWS * COORD_W + 1;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = NUM_ROWS * COORD_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_VAL_LSB   = IDX_W;
    localparam int IN_COORD_LSB = IDX_W + COEF_W;
    localparam int IN_LOST_BIT  = IN_COORD_LSB + NUM_ROWS * COORD_W;
    localparam int OUT_LOST_BIT = NUM_ROWS * COORD_W;
    localparam int OUT_SAT_BIT  = OUT_LOST_BIT + 1;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_PARTICLE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef coord_t [NUM_ROWS-1:0]     coord_vec_t;

    typedef struct packed {
        coord_t value;
        logic   clip;
    } lane_res_t;

    typedef lane_res_t [NUM_ROWS-1:0] lane_res_vec_t;

    // Load enables of each pipeline register rank.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic so;
    } pipe_en_t;

endpackage

// ===== rtl/core/apsm_ctrl.sv =====
// Valid tracking and per-stage load enables for the elastic pipeline.
module apsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              part_acc,
    input  logic              m_tready,
    output logic              s_tready,
    output logic              m_tvalid,
    output apsm_pkg::pipe_en_t en
);

    logic [apsm_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [apsm_pkg::PIPE_DEPTH-1:0] vld_next;
    logic [apsm_pkg::PIPE_DEPTH-1:0] en_vec;

    // A rank loads when it is empty or when the rank after it loads, so
    // bubbles collapse and the input keeps flowing behind a stalled result.
    always_comb
    begin
        en_vec[apsm_pkg::PIPE_DEPTH-1] = !vld_reg[apsm_pkg::PIPE_DEPTH-1] || m_tready;
        for (int i = apsm_pkg::PIPE_DEPTH - 2; i >= 0; i--)
        begin
            en_vec[i] = !vld_reg[i] || en_vec[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en_vec[0] ? part_acc : vld_reg[0];
        for (int i = 1; i < apsm_pkg::PIPE_DEPTH; i++)
        begin
            vld_next[i] = en_vec[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        en.s1 = en_vec[0];
        en.s2 = en_vec[1];
        en.s3 = en_vec[2];
        en.s4 = en_vec[3];
        en.s5 = en_vec[4];
        en.so = en_vec[5];
    end

    assign s_tready = en_vec[0];
    assign m_tvalid = vld_reg[apsm_pkg::PIPE_DEPTH-1];

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && en_vec[1] |=> vld_reg[1])
        else $error("transaction dropped between first and second rank");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg & ~en_vec) != '0 |=> (($past(vld_reg & ~en_vec) & ~vld_reg) == '0))
        else $error("stalled rank lost its transaction");

endmodule

// ===== rtl/core/apsm_lane.sv =====
// One output row: coefficient storage, six multipliers, adder tree, rounding and clipping.
module apsm_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  apsm_pkg::pipe_en_t               en,
    input  logic [apsm_pkg::NUM_COLS-1:0]    coef_we,
    input  apsm_pkg::coef_t                  coef_wdata,
    input  apsm_pkg::coord_vec_t             vin,
    output apsm_pkg::lane_res_t              res
);

    apsm_pkg::coef_t coef_reg [apsm_pkg::NUM_COLS];

    apsm_pkg::coord_t                     v [apsm_pkg::NUM_ROWS];
    logic signed [apsm_pkg::PROD_W-1:0]   prod_next [apsm_pkg::NUM_ROWS];
    logic signed [apsm_pkg::PROD_W-1:0]   prod_reg  [apsm_pkg::NUM_ROWS];
    logic signed [apsm_pkg::SUM2_W-1:0]   pair_reg  [3];
    logic signed [apsm_pkg::SUM3_W-1:0]   quad_a_reg;
    logic signed [apsm_pkg::SUM3_W-1:0]   quad_b_reg;
    logic signed [apsm_pkg::SUM4_W-1:0]   total_reg;
    apsm_pkg::coord_t                     off1_reg, off2_reg, off3_reg, off4_reg;
    logic signed [apsm_pkg::SHR_W-1:0]    shr;
    logic signed [apsm_pkg::RES_W-1:0]    r;
    logic [apsm_pkg::RES_W-apsm_pkg::COORD_W:0] top_bits;
    logic                                 ovf;
    apsm_pkg::coord_t                     value_next;
    apsm_pkg::coord_t                     value_reg;
    logic                                 clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < apsm_pkg::NUM_COLS; c++)
            begin
                coef_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < apsm_pkg::NUM_COLS; c++)
            begin
                if (coef_we[c])
                begin
                    coef_reg[c] <= coef_wdata;
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < apsm_pkg::NUM_ROWS; c++)
        begin
            v[c]         = $signed(vin[c]);
            prod_next[c] = coef_reg[c+1] * v[c];
        end
    end

    // Column 0 holds the offset; it is captured with the products so that a
    // later load cannot change a particle already in flight.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int c = 0; c < apsm_pkg::NUM_ROWS; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
            off1_reg <= coef_reg[0];
        end
        if (en.s2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pair_reg[k] <= apsm_pkg::SUM2_W'(prod_reg[2*k])
                             + apsm_pkg::SUM2_W'(prod_reg[2*k+1]);
            end
            off2_reg <= off1_reg;
        end
        if (en.s3)
        begin
            quad_a_reg <= apsm_pkg::SUM3_W'(pair_reg[0]) + apsm_pkg::SUM3_W'(pair_reg[1]);
            quad_b_reg <= apsm_pkg::SUM3_W'(pair_reg[2]) + apsm_pkg::ROUND_HALF;
            off3_reg   <= off2_reg;
        end
        if (en.s4)
        begin
            total_reg <= apsm_pkg::SUM4_W'(quad_a_reg) + apsm_pkg::SUM4_W'(quad_b_reg);
            off4_reg  <= off3_reg;
        end
        if (en.s5)
        begin
            value_reg <= value_next;
            clip_reg  <= ovf;
        end
    end

    // Floor shift of the rounded sum, then the offset, then clip to the coordinate range.
    assign shr      = total_reg[apsm_pkg::SUM4_W-1:apsm_pkg::COEF_FRAC];
    assign r        = apsm_pkg::RES_W'(shr) + apsm_pkg::RES_W'(off4_reg);
    assign top_bits = r[apsm_pkg::RES_W-1:apsm_pkg::COORD_W-1];
    assign ovf      = !((&top_bits) || (top_bits == '0));

    always_comb
    begin
        if (!ovf)
        begin
            value_next = r[apsm_pkg::COORD_W-1:0];
        end
        else if (r[apsm_pkg::RES_W-1])
        begin
            value_next = {1'b1, {(apsm_pkg::COORD_W-1){1'b0}}};
        end
        else
        begin
            value_next = {1'b0, {(apsm_pkg::COORD_W-1){1'b1}}};
        end
    end

    assign res.value = value_reg;
    assign res.clip  = clip_reg;

endmodule

// ===== rtl/core/apsm_merge.sv =====
// Pass-through delay line for lost particles and the output register that combines the lanes.
module apsm_merge (
    input  logic                   clk,
    input  apsm_pkg::pipe_en_t     en,
    input  apsm_pkg::coord_vec_t   vin,
    input  logic                   lost_in,
    input  apsm_pkg::lane_res_vec_t lane_res,
    output apsm_pkg::coord_vec_t   vout,
    output logic                   lost_out,
    output logic                   saturated
);

    apsm_pkg::coord_vec_t dly_reg [apsm_pkg::PIPE_DEPTH-1];
    logic                 lost_reg [apsm_pkg::PIPE_DEPTH-1];
    logic [apsm_pkg::PIPE_DEPTH-2:0] en_dly;
    apsm_pkg::coord_vec_t out_coord_reg;
    logic                 out_lost_reg;
    logic                 out_sat_reg;
    apsm_pkg::coord_vec_t lane_vals;
    logic                 any_clip;

    assign en_dly = {en.s5, en.s4, en.s3, en.s2, en.s1};

    always_ff @(posedge clk)
    begin
        if (en_dly[0])
        begin
            dly_reg[0]  <= vin;
            lost_reg[0] <= lost_in;
        end
        for (int i = 1; i < apsm_pkg::PIPE_DEPTH - 1; i++)
        begin
            if (en_dly[i])
            begin
                dly_reg[i]  <= dly_reg[i-1];
                lost_reg[i] <= lost_reg[i-1];
            end
        end
    end

    always_comb
    begin
        any_clip = 1'b0;
        for (int r = 0; r < apsm_pkg::NUM_ROWS; r++)
        begin
            lane_vals[r] = lane_res[r].value;
            any_clip     = any_clip | lane_res[r].clip;
        end
    end

    // A lost particle leaves with its input coordinates and no clip flag.
    always_ff @(posedge clk)
    begin
        if (en.so)
        begin
            if (lost_reg[apsm_pkg::PIPE_DEPTH-2])
            begin
                out_coord_reg <= dly_reg[apsm_pkg::PIPE_DEPTH-2];
                out_lost_reg  <= 1'b1;
                out_sat_reg   <= 1'b0;
            end
            else
            begin
                out_coord_reg <= lane_vals;
                out_lost_reg  <= 1'b0;
                out_sat_reg   <= any_clip;
            end
        end
    end

    assign vout      = out_coord_reg;
    assign lost_out  = out_lost_reg;
    assign saturated = out_sat_reg;

endmodule

// ===== rtl/core/affine_phase_space_map.sv =====
// Top level of the affine phase-space map: six row lanes, control and output merge.
//
// Usage:
// The slave stream carries two kinds of transaction, chosen by s_tuser.
// A load (s_tuser low) writes one entry of the 6-by-7 coefficient table at
// row*7+col; column 0 of each row is the offset in coordinate format, and
// indexes above 41 are dropped. A load produces no result.
// A particle (s_tuser high) is mapped row by row as offset plus the dot
// product of the row with (x, px, y, py, ct, de), rounded half up to Q8.24
// and clipped; a lost particle leaves unchanged with saturated low.
// A particle passes six register ranks: a multiplier rank, three adder ranks,
// a round-and-clip rank in each lane and the output register. The first rank
// loads at the accepting edge; m_tvalid rises once the particle reaches the output register.
// Throughput is one transaction per cycle; the pipeline is
// elastic, so empty ranks fill while a result waits on m_tready and the
// input stalls only once every rank holds a particle.
// Loads take effect for particles accepted after them.
// Reset clears the coefficient table and empties the pipeline.
module affine_phase_space_map (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coef_index, coef_value, x_in, px_in, y_in, py_in, ct_in, de_in, lost_in, zero pad
    input  logic [apsm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // x_out, px_out, y_out, py_out, ct_out, de_out, lost_out, saturated, zero pad
    output logic [apsm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic                    acc;
    logic                    part_acc;
    logic                    load_acc;
    logic [apsm_pkg::IDX_W-1:0] idx;
    apsm_pkg::coef_t         wval;
    apsm_pkg::coord_vec_t    vin;
    logic                    lost_in;
    apsm_pkg::pipe_en_t      en;
    apsm_pkg::lane_res_vec_t lane_res;
    apsm_pkg::coord_vec_t    vout;
    logic                    lost_out;
    logic                    saturated;
    logic [apsm_pkg::NUM_COLS-1:0] coef_we [apsm_pkg::NUM_ROWS];

    assign acc      = s_tvalid && s_tready;
    assign part_acc = acc && (s_tuser == apsm_pkg::CMD_PARTICLE);
    assign load_acc = acc && (s_tuser == apsm_pkg::CMD_LOAD);
    assign idx      = s_tdata[apsm_pkg::IDX_W-1:0];
    assign wval     = s_tdata[apsm_pkg::IN_VAL_LSB +: apsm_pkg::COEF_W];
    assign lost_in  = s_tdata[apsm_pkg::IN_LOST_BIT];

    always_comb
    begin
        for (int r = 0; r < apsm_pkg::NUM_ROWS; r++)
        begin
            vin[r] = s_tdata[apsm_pkg::IN_COORD_LSB + r*apsm_pkg::COORD_W +: apsm_pkg::COORD_W];
            for (int c = 0; c < apsm_pkg::NUM_COLS; c++)
            begin
                coef_we[r][c] = load_acc
                    && (idx == apsm_pkg::IDX_W'(r * apsm_pkg::NUM_COLS + c));
            end
        end
    end

    apsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .part_acc (part_acc),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .en       (en)
    );

    for (genvar g = 0; g < apsm_pkg::NUM_ROWS; g++)
    begin : g_lane
        apsm_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .coef_we    (coef_we[g]),
            .coef_wdata (wval),
            .vin        (vin),
            .res        (lane_res[g])
        );
    end

    apsm_merge u_merge (
        .clk       (clk),
        .en        (en),
        .vin       (vin),
        .lost_in   (lost_in),
        .lane_res  (lane_res),
        .vout      (vout),
        .lost_out  (lost_out),
        .saturated (saturated)
    );

    always_comb
    begin
        m_tdata = '0;
        for (int r = 0; r < apsm_pkg::NUM_ROWS; r++)
        begin
            m_tdata[r*apsm_pkg::COORD_W +: apsm_pkg::COORD_W] = vout[r];
        end
        m_tdata[apsm_pkg::OUT_LOST_BIT] = lost_out;
        m_tdata[apsm_pkg::OUT_SAT_BIT]  = saturated;
    end

endmodule

// ===== tb/affine_phase_space_map_tb.sv =====
// Self-checking stream testbench for the affine phase-space map.
`timescale 1ns / 1ps

module affine_phase_space_map_tb;

    localparam int TOTAL_ITEMS    = 1550;
    localparam int TAIL_ITEMS     = 150;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 150;
    localparam int IN_W           = apsm_pkg::IN_TDATA_W;
    localparam int OUT_W          = apsm_pkg::OUT_TDATA_W;
    localparam int ROWS           = apsm_pkg::NUM_ROWS;
    localparam int COLS           = apsm_pkg::NUM_COLS;
    localparam int TSIZE          = apsm_pkg::TABLE_SIZE;
    localparam int CW             = apsm_pkg::COORD_W;
    localparam int INDEX_SPAN     = 1 << apsm_pkg::IDX_W;
    localparam logic [31:0] ONE_COEF = 32'h0040_0000;
    localparam logic [31:0] MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_WORD = 32'h8000_0000;
    localparam int HALF_LSB = 1 << (apsm_pkg::COEF_FRAC - 1);

    typedef struct {
        logic                      cmd;
        logic [apsm_pkg::IDX_W-1:0] idx;
        apsm_pkg::coef_t           value;
        apsm_pkg::coord_vec_t      coords;
        logic                      lost;
    } phase_item_t;

    typedef struct {
        apsm_pkg::coord_vec_t coords;
        logic                 lost;
        logic                 sat;
    } phase_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    phase_item_t     item_q[$];
    phase_result_t   mapped_q[$];
    apsm_pkg::coef_t coef_mirror[TSIZE] = '{default: '0};
    phase_item_t     held;
    string           coord_names[ROWS] = '{"x", "px", "y", "py", "ct", "de"};

    int n_errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int gap_left = 0;
    int gap_pct = 20;
    int stall_left = 0;
    int stall_pct = 20;
    int hold_left = 0;
    int idle_cycles = 0;

    affine_phase_space_map dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] rand_word(input int min_shift, input int max_shift);
        logic signed [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return w;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return MAX_WORD;
                    1: return MIN_WORD;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return w >>> $urandom_range(max_shift, min_shift);
        endcase
    endfunction

    function automatic apsm_pkg::coord_vec_t coords_of(
        input apsm_pkg::coord_t x, input apsm_pkg::coord_t px, input apsm_pkg::coord_t y,
        input apsm_pkg::coord_t py, input apsm_pkg::coord_t ct, input apsm_pkg::coord_t de);
        apsm_pkg::coord_vec_t c;
        c[0] = x;
        c[1] = px;
        c[2] = y;
        c[3] = py;
        c[4] = ct;
        c[5] = de;
        return c;
    endfunction

    // Fields the block ignores for a given command still carry random values.
    function automatic phase_item_t load_item(input int idx, input logic [31:0] value);
        phase_item_t it;
        it.cmd   = apsm_pkg::CMD_LOAD;
        it.idx   = apsm_pkg::IDX_W'(idx);
        it.value = value;
        for (int i = 0; i < ROWS; i++)
            it.coords[i] = $urandom;
        it.lost = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic phase_item_t particle_item(input apsm_pkg::coord_vec_t c,
                                                  input logic lost);
        phase_item_t it;
        it.cmd    = apsm_pkg::CMD_PARTICLE;
        it.idx    = apsm_pkg::IDX_W'($urandom_range(0, INDEX_SPAN - 1));
        it.value  = $urandom;
        it.coords = c;
        it.lost   = lost;
        return it;
    endfunction

    // Sum the exact products, round half up into coordinate format, add the offset, clip.
    function automatic phase_result_t map_particle(input phase_item_t it);
        phase_result_t r;
        logic signed [71:0] acc;
        logic signed [71:0] lim_hi;
        logic signed [71:0] lim_lo;
        lim_hi = (72'sd1 <<< (CW - 1)) - 72'sd1;
        lim_lo = -(72'sd1 <<< (CW - 1));
        r.coords = it.coords;
        r.lost   = it.lost;
        r.sat    = 1'b0;
        if (!it.lost)
        begin
            for (int row = 0; row < ROWS; row++)
            begin
                acc = '0;
                for (int c = 1; c < COLS; c++)
                    acc = acc + $signed(coef_mirror[row * COLS + c])
                              * $signed(it.coords[c - 1]);
                acc = ((acc + (72'sd1 <<< (apsm_pkg::COEF_FRAC - 1))) >>> apsm_pkg::COEF_FRAC)
                      + $signed(coef_mirror[row * COLS]);
                if (acc > lim_hi)
                begin
                    acc   = lim_hi;
                    r.sat = 1'b1;
                end
                else if (acc < lim_lo)
                begin
                    acc   = lim_lo;
                    r.sat = 1'b1;
                end
                r.coords[row] = acc[CW-1:0];
            end
        end
        return r;
    endfunction

    task automatic apply_item(input phase_item_t it);
        if (it.cmd == apsm_pkg::CMD_LOAD)
        begin
            if (it.idx < TSIZE)
                coef_mirror[it.idx] = it.value;
        end
        else
        begin
            mapped_q.push_back(map_particle(it));
        end
    endtask

    task automatic compare_word(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%s mismatch in result %0d: expected %h, got %h",
                         what, n_results, want, got);
        end
    endtask

    initial
    begin : stimulus
        apsm_pkg::coord_vec_t c;
        int idx;
        rst_n = 1'b0;

        // The cleared table maps every particle to zero.
        item_q.push_back(particle_item(
            coords_of(MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD, 0, -1), 0));
        for (int r = 0; r < ROWS; r++)
            item_q.push_back(load_item(r * COLS + r + 1, ONE_COEF));
        item_q.push_back(particle_item(
            coords_of(MAX_WORD, MIN_WORD, 1, -1, MIN_WORD, MAX_WORD), 0));
        // Loads past the end of the table must leave it untouched.
        item_q.push_back(load_item(TSIZE, MAX_WORD));
        item_q.push_back(load_item(INDEX_SPAN - 1, MIN_WORD));
        item_q.push_back(load_item(0, MAX_WORD));
        item_q.push_back(load_item(COLS + 1, MIN_WORD));
        item_q.push_back(particle_item(coords_of(MAX_WORD, 0, 0, 0, 0, 0), 0));
        item_q.push_back(particle_item(coords_of(MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD,
                                                 MAX_WORD, MIN_WORD), 1));
        // Exact half steps round toward plus infinity.
        item_q.push_back(load_item(2 * COLS + 1, 1));
        item_q.push_back(particle_item(coords_of(HALF_LSB, 0, 0, 0, 0, 0), 0));
        item_q.push_back(particle_item(coords_of(-HALF_LSB, 0, 0, 0, 0, 0), 0));
        item_q.push_back(particle_item(coords_of(3 * HALF_LSB, 0, 0, 0, 0, 0), 0));
        item_q.push_back(load_item(TSIZE - 1, MIN_WORD));
        item_q.push_back(particle_item(coords_of(0, 0, 0, 0, 0, MIN_WORD), 0));
        item_q.push_back(load_item(5 * COLS, MIN_WORD));
        item_q.push_back(particle_item(coords_of(0, 0, 0, 0, 0, 0), 0));
        item_q.push_back(particle_item(coords_of(0, 0, 0, 0, 0, MAX_WORD), 0));

        while (item_q.size() < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                idx = ($urandom_range(0, 19) == 0) ? $urandom_range(TSIZE, INDEX_SPAN - 1)
                                                   : $urandom_range(0, TSIZE - 1);
                item_q.push_back(load_item(idx, rand_word(6, 12)));
            end
            else
            begin
                for (int i = 0; i < ROWS; i++)
                    c[i] = rand_word(3, 10);
                item_q.push_back(particle_item(c, $urandom_range(0, 9) == 0));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (item_q.size() != 0 || s_tvalid || mapped_q.size() != 0)
            @(posedge clk);
        repeat (apsm_pkg::PIPE_DEPTH * 4) @(posedge clk);
        if (n_errors == 0 && mapped_q.size() == 0)
            $display("affine_phase_space_map_tb OK");
        else
            $display("affine_phase_space_map_tb NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin : stim_drive
        logic offer;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_item(held);
                n_sent++;
                if (n_sent % 100 == 0)
                    gap_pct = $urandom_range(0, 3) * 12;
            end
            if (!s_tvalid || s_tready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (item_q.size() != 0)
                begin
                    if (item_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < gap_pct)
                    begin
                        gap_left = $urandom_range(0, 8);
                    end
                    else
                    begin
                        held  = item_q.pop_front();
                        offer = 1'b1;
                    end
                end
                s_tvalid <= offer;
                s_tdata  <= IN_W'({held.lost, held.coords, held.value, held.idx});
                s_tuser  <= held.cmd;
            end
        end
    end

    always @(posedge clk)
    begin : result_watch
        phase_result_t want;
        logic rdy;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (mapped_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result transaction: %h", m_tdata);
                end
                else
                begin
                    want = mapped_q.pop_front();
                    for (int i = 0; i < ROWS; i++)
                        compare_word(coord_names[i], want.coords[i],
                                     m_tdata[i * CW +: CW]);
                    compare_word("lost", 32'(want.lost),
                                 32'(m_tdata[apsm_pkg::OUT_LOST_BIT]));
                    compare_word("saturated", 32'(want.sat),
                                 32'(m_tdata[apsm_pkg::OUT_SAT_BIT]));
                end
                n_results++;
                // One long hold-off lets the pipeline fill and push back on the input.
                if (n_results == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                if (n_results % 100 == 0)
                    stall_pct = $urandom_range(0, 3) * 12;
            end
            rdy = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (item_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(0, 8);
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("affine_phase_space_map_tb NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
